@@ design/japanese_word_type_classifier_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Japanese word-type classifier
// Short forms for clocked implication checks used by the checker module.
// ----------------------------------------------------------------------------
`ifndef JAPANESE_WORD_TYPE_CLASSIFIER_MACROS_SVH
`define JAPANESE_WORD_TYPE_CLASSIFIER_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define JWTC_ASSERT_SAME(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error("jwtc: same-cycle check failed");

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define JWTC_ASSERT_NEXT(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("jwtc: next-cycle check failed");

`endif

@@ design/jwtc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Japanese word-type classifier package
// Shared widths, class masks, queue entry type and the word-type decision.
// ----------------------------------------------------------------------------
package jwtc_pkg;

   localparam int CODE_POINT_WIDTH    = 21;
   localparam int WORD_TYPE_WIDTH     = 4;
   localparam int CLASS_COUNT         = 7;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // One bit per character class, in the order alphabet, number, dash,
   // hiragana, katakana, kanji, symbol.
   localparam logic [CLASS_COUNT-1:0] MASK_ALPHA  = 7'b000_0001;
   localparam logic [CLASS_COUNT-1:0] MASK_NUMBER = 7'b000_0010;
   localparam logic [CLASS_COUNT-1:0] MASK_DASH   = 7'b000_0100;
   localparam logic [CLASS_COUNT-1:0] MASK_HIRA   = 7'b000_1000;
   localparam logic [CLASS_COUNT-1:0] MASK_KATA   = 7'b001_0000;
   localparam logic [CLASS_COUNT-1:0] MASK_KANJI  = 7'b010_0000;
   localparam logic [CLASS_COUNT-1:0] MASK_SYMBOL = 7'b100_0000;

   typedef enum logic [WORD_TYPE_WIDTH-1:0] {
      WT_ALPHABET       = 4'd0,
      WT_NUMBER         = 4'd1,
      WT_HIRAGANA       = 4'd2,
      WT_KATAKANA       = 4'd3,
      WT_KANJI          = 4'd4,
      WT_SYMBOL         = 4'd5,
      WT_KANJI_HIRAGANA = 4'd6,
      WT_KANJI_KATAKANA = 4'd7,
      WT_OTHER          = 4'd8
   } word_type_type;

   // A classified character as it travels from the front end to the back end.
   typedef struct packed {
      logic                   last;
      logic [CLASS_COUNT-1:0] cls;
   } item_type;

   function automatic logic only_in(input logic [CLASS_COUNT-1:0] s,
                                    input logic [CLASS_COUNT-1:0] allowed);
      return (s & ~allowed) == '0;
   endfunction

   // Maps the set of classes seen in a word to its word-type code.
   function automatic word_type_type decide(input logic [CLASS_COUNT-1:0] s);
      word_type_type wt;
      if (s == MASK_ALPHA) begin
         wt = WT_ALPHABET;
      end else if (s == MASK_NUMBER) begin
         wt = WT_NUMBER;
      end else if (only_in(s, MASK_HIRA | MASK_DASH)) begin
         wt = WT_HIRAGANA;
      end else if (only_in(s, MASK_KATA | MASK_DASH)) begin
         wt = WT_KATAKANA;
      end else if (s == MASK_KANJI) begin
         wt = WT_KANJI;
      end else if (s == MASK_SYMBOL) begin
         wt = WT_SYMBOL;
      end else if ((s & MASK_KANJI) != '0 && (s & MASK_HIRA) != '0 &&
                   only_in(s, MASK_HIRA | MASK_KANJI | MASK_DASH)) begin
         wt = WT_KANJI_HIRAGANA;
      end else if ((s & MASK_KANJI) != '0 && (s & MASK_KATA) != '0 &&
                   only_in(s, MASK_KATA | MASK_KANJI | MASK_DASH)) begin
         wt = WT_KANJI_KATAKANA;
      end else begin
         wt = WT_OTHER;
      end
      return wt;
   endfunction

endpackage

@@ design/japanese_word_type_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Japanese word-type classifier
// Classifies a word, one code point per request, into a single word type.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Content
//   --------+-----------+-----------------------------------------------------
//   req_    | in        | code point of one character, tlast on the word's end
//   rsp_    | out       | word-type code, one per word
//
// One request is taken in every clock cycle when nothing stalls. A word's
// result passes through the front end register and the queue into the
// result register, where it sits until it is taken. The front end and the
// back end each run at one character a cycle when not stalled, and the
// queue lets them stall independently. A stall on rsp_ only holds back
// characters that end a word; other characters keep draining.
// Reset clears the presence bits, the queue and both valid flags.
// ----------------------------------------------------------------------------
module japanese_word_type_classifier
   import jwtc_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [20:0] code_point, [23:21] zero
   input  logic        req_tlast,   // last_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [3:0] word_type, [7:4] zero
);

   // Classified characters leaving the front end and entering the queue.
   logic          push_valid;
   logic          push_ready;
   item_type      push_item;

   // Characters leaving the queue for the back end.
   logic          pop_valid;
   logic          pop_ready;
   item_type      pop_item;

   word_type_type word_type;

   // Front end: registers each request and turns the code point into a
   // one-hot class in priority order.
   jwtc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .code_point (req_tdata[CODE_POINT_WIDTH-1:0]),
      .last_char  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // Queue: decouples classification from the result side.
   jwtc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // Back end: collects presence bits and issues the word type when the
   // last character of a word arrives, clearing the bits for the next word.
   jwtc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .word_type (word_type)
   );

   assign rsp_tdata = {{(8 - WORD_TYPE_WIDTH){1'b0}}, word_type};

endmodule

@@ design/jwtc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Classifier front end
// Registers each request and reduces its code point to a one-hot class.
// ----------------------------------------------------------------------------
module jwtc_front
   import jwtc_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [CODE_POINT_WIDTH-1:0] code_point,
   input  logic                        last_char,
   output logic                        push_valid,
   input  logic                        push_ready,
   output item_type                    push_item
);

   typedef struct packed {
      logic [CODE_POINT_WIDTH-1:0] lo;
      logic [CODE_POINT_WIDTH-1:0] hi;
   } span_type;

   localparam int SPAN_COUNT = 8;

   localparam span_type NUMBER_SPANS [SPAN_COUNT] = '{
      '{21'h00030, 21'h00039}, '{21'h02150, 21'h0218F}, '{21'h0A830, 21'h0A83F},
      '{21'h10100, 21'h1013F}, '{21'h10140, 21'h1018F}, '{21'h102E0, 21'h102FF},
      '{21'h111E0, 21'h111FF}, '{21'h12400, 21'h1247F}
   };

   localparam span_type KANJI_SPANS [SPAN_COUNT] = '{
      '{21'h04E00, 21'h09FFF}, '{21'h03400, 21'h04DBF}, '{21'h20000, 21'h2A6DF},
      '{21'h2A700, 21'h2B73F}, '{21'h2B740, 21'h2B81F}, '{21'h2B820, 21'h2CEAF},
      '{21'h2CEB0, 21'h2EBEF}, '{21'h02E80, 21'h02EFF}
   };

   localparam logic [CODE_POINT_WIDTH-1:0] CP_DASH = 21'h030FC;

   function automatic logic [CLASS_COUNT-1:0] classify(
      input logic [CODE_POINT_WIDTH-1:0] c);
      logic                   number_hit;
      logic                   ideograph_hit;
      logic [CLASS_COUNT-1:0] cls;
      number_hit    = 1'b0;
      ideograph_hit = 1'b0;
      for (int i = 0; i < SPAN_COUNT; i++) begin
         number_hit    |= (c >= NUMBER_SPANS[i].lo) && (c <= NUMBER_SPANS[i].hi);
         ideograph_hit |= (c >= KANJI_SPANS[i].lo) && (c <= KANJI_SPANS[i].hi);
      end
      priority if ((c >= 21'h41 && c <= 21'h5A) || (c >= 21'h61 && c <= 21'h7A)) begin
         cls = MASK_ALPHA;
      end else if (number_hit) begin
         cls = MASK_NUMBER;
      end else if (c == CP_DASH) begin
         cls = MASK_DASH;
      end else if (c >= 21'h03040 && c <= 21'h0309F) begin
         cls = MASK_HIRA;
      end else if ((c >= 21'h030A0 && c <= 21'h030FF) ||
                   (c >= 21'h031F0 && c <= 21'h031FF)) begin
         cls = MASK_KATA;
      end else if (ideograph_hit) begin
         cls = MASK_KANJI;
      end else begin
         cls = MASK_SYMBOL;
      end
      return cls;
   endfunction

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   item_type item_in;

   assign in_ready   = !valid_ff || push_ready;
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   always_comb begin
      valid_in     = in_ready ? in_valid : valid_ff;
      item_in.last = last_char;
      item_in.cls  = classify(code_point);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

@@ design/jwtc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Classified-character queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module jwtc_queue
   import jwtc_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   localparam int PTR_WIDTH   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   item_type               slot_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff;
   logic [PTR_WIDTH-1:0]   wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff;
   logic [PTR_WIDTH-1:0]   rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = count_ff != COUNT_WIDTH'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ design/jwtc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Classifier back end
// Gathers class presence bits per word and registers the word-type result.
// ----------------------------------------------------------------------------
module jwtc_back
   import jwtc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          pop_valid,
   output logic          pop_ready,
   input  item_type      pop_item,
   output logic          out_valid,
   input  logic          out_ready,
   output word_type_type word_type
);

   logic [CLASS_COUNT-1:0] seen_ff;
   logic [CLASS_COUNT-1:0] seen_in;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   word_type_type          word_ff;
   logic [CLASS_COUNT-1:0] merged;
   logic                   take;

   // A character that ends no word only touches the presence bits, so it
   // never waits on the result register.
   assign pop_ready = !pop_item.last || !out_valid_ff || out_ready;
   assign take      = pop_valid && pop_ready;
   assign merged    = seen_ff | pop_item.cls;
   assign out_valid = out_valid_ff;
   assign word_type = word_ff;

   always_comb begin
      seen_in      = seen_ff;
      out_valid_in = out_valid_ff && !out_ready;
      if (take) begin
         seen_in = pop_item.last ? '0 : merged;
         if (pop_item.last) begin
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         seen_ff      <= seen_in;
         out_valid_ff <= out_valid_in;
      end
      if (take && pop_item.last) begin
         word_ff <= decide(merged);
      end
   end

endmodule

@@ design/jwtc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Classifier port checker
// Watches the top-level ports for response behaviour over time.
// ----------------------------------------------------------------------------
`include "japanese_word_type_classifier_macros.svh"

module jwtc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   // A stalled response keeps its value.
   `JWTC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // Only the nine defined word-type codes ever leave the block.
   `JWTC_ASSERT_SAME(a_rsp_code, clock, reset, rsp_tvalid, rsp_tdata[7:4] == 4'd0 && rsp_tdata[3:0] <= 4'd8)

   // Reset leaves no response pending.
   `JWTC_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_tvalid)

   // A response never rises straight out of reset.
   `JWTC_ASSERT_SAME(a_rsp_cause, clock, reset, $rose(rsp_tvalid), !$past(reset) && !$past(reset, 2))

endmodule

bind japanese_word_type_classifier jwtc_checker u_checker (.*);
